// ===== rtl/core/php_pkg.sv =====
package php_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int PIXEL_BITS_DEF = 12;

  localparam int FOCAL_W = 18;
  localparam int SIZE_W  = 13;
  localparam int DEPTH_W = 23;
  localparam int COLOR_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int FRAC_BITS  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTRE_X = 3'd2,
    REG_CENTRE_Y = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_MIN_DEPTH = 3'd6
  } reg_idx_t;

  localparam logic [FOCAL_W-1:0] FOCAL_X_RST  = 18'd117910;
  localparam logic [FOCAL_W-1:0] FOCAL_Y_RST  = 18'd117829;
  localparam logic [FOCAL_W-1:0] CENTRE_X_RST = 18'd85525;
  localparam logic [FOCAL_W-1:0] CENTRE_Y_RST = 18'd43471;
  localparam logic [SIZE_W-1:0]  WIDTH_RST    = 13'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST   = 13'd360;
  localparam logic [DEPTH_W-1:0] DEPTH_RST    = 23'd460;

endpackage

// ===== rtl/core/php_if.sv =====
interface php_in_if #(
  parameter int COORD_BITS = php_pkg::COORD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS-1:0]   point_x_mm;
  logic signed [COORD_BITS-1:0]   point_y_mm;
  logic signed [COORD_BITS-1:0]   point_z_mm;
  logic [php_pkg::COLOR_W-1:0]    red_in;
  logic [php_pkg::COLOR_W-1:0]    green_in;
  logic [php_pkg::COLOR_W-1:0]    blue_in;
  logic                           finite;

  modport source (output valid, point_x_mm, point_y_mm, point_z_mm, red_in, green_in,
                  blue_in, finite, input ready);
  modport sink (input valid, point_x_mm, point_y_mm, point_z_mm, red_in, green_in,
                blue_in, finite, output ready);
endinterface

interface php_out_if #(
  parameter int PIXEL_BITS = php_pkg::PIXEL_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        write_pixel;
  logic [PIXEL_BITS-1:0]       column;
  logic [PIXEL_BITS-1:0]       row;
  logic [php_pkg::COLOR_W-1:0] red_out;
  logic [php_pkg::COLOR_W-1:0] green_out;
  logic [php_pkg::COLOR_W-1:0] blue_out;

  modport source (output valid, write_pixel, column, row, red_out, green_out, blue_out,
                  input ready);
  modport sink (input valid, write_pixel, column, row, red_out, green_out, blue_out,
                output ready);
endinterface

interface php_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [php_pkg::CFG_IDX_W-1:0]  index;
  logic [php_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/pinhole_point_projection.sv =====
// Throughput: one point per cycle unless the output stalls; the restoring divider is
// unrolled one quotient bit per pipeline stage, so each stage holds one point.
// A stall at the output freezes the whole pipeline; in_ready is high whenever the output
// register is empty or its beat is taken in the same cycle.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module pinhole_point_projection #(
  parameter int COORD_BITS = php_pkg::COORD_BITS_DEF,
  parameter int PIXEL_BITS = php_pkg::PIXEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  php_in_if.sink       in_bus,
  php_out_if.source    out_bus,
  php_cfg_if.sink      cfg_bus
);
  import php_pkg::*;

  // Product magnitude, divisor, signed sum and shifted magnitude widths.
  localparam int PB = COORD_BITS + FOCAL_W;
  localparam int DB = COORD_BITS - 1;
  localparam int SB = PB + 2;
  localparam int MB = SB - FRAC_BITS;
  localparam int CW = ((COORD_BITS > DEPTH_W) ? COORD_BITS : DEPTH_W) + 1;
  localparam int LW = ((SIZE_W > PIXEL_BITS) ? SIZE_W : PIXEL_BITS) + 1;
  // Stages: input, product, PB divider steps, sum, output.
  localparam int NS = PB + 4;
  localparam int SIDE_N = PB + 3;

  typedef struct packed {
    logic               keep;
    logic               sx;
    logic               sy;
    logic [DB-1:0]      div;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } side_t;

  // Configuration registers
  logic [FOCAL_W-1:0] fx_r, fy_r, cx_r, cy_r;
  logic [SIZE_W-1:0]  width_r, height_r;
  logic [DEPTH_W-1:0] min_depth_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r        <= FOCAL_X_RST;
      fy_r        <= FOCAL_Y_RST;
      cx_r        <= CENTRE_X_RST;
      cy_r        <= CENTRE_Y_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      min_depth_r <= DEPTH_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_FOCAL_X:   fx_r        <= cfg_bus.data[FOCAL_W-1:0];
        REG_FOCAL_Y:   fy_r        <= cfg_bus.data[FOCAL_W-1:0];
        REG_CENTRE_X:  cx_r        <= cfg_bus.data[FOCAL_W-1:0];
        REG_CENTRE_Y:  cy_r        <= cfg_bus.data[FOCAL_W-1:0];
        REG_WIDTH:     width_r     <= cfg_bus.data[SIZE_W-1:0];
        REG_HEIGHT:    height_r    <= cfg_bus.data[SIZE_W-1:0];
        REG_MIN_DEPTH: min_depth_r <= cfg_bus.data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: advance everything when the output slot is free or taken.
  logic          adv;
  logic [NS-1:0] valid_r;

  assign adv          = !valid_r[NS-1] || out_bus.ready;
  assign in_bus.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NS-2:0], in_bus.valid};
    end
  end

  // Stage 0: drop test, magnitudes and signs.
  logic signed [CW-1:0]   z_ext, min_ext;
  logic [COORD_BITS-1:0]  ax_nxt, ay_nxt;
  side_t                  side_nxt;
  logic [COORD_BITS-1:0]  ax_r, ay_r;
  side_t                  side_r [SIDE_N];

  assign z_ext   = {{(CW-COORD_BITS){in_bus.point_z_mm[COORD_BITS-1]}}, in_bus.point_z_mm};
  assign min_ext = {{(CW-DEPTH_W){1'b0}}, min_depth_r};

  always_comb begin
    ax_nxt = in_bus.point_x_mm[COORD_BITS-1] ? (~in_bus.point_x_mm + 1'b1)
                                              : in_bus.point_x_mm;
    ay_nxt = in_bus.point_y_mm[COORD_BITS-1] ? (~in_bus.point_y_mm + 1'b1)
                                              : in_bus.point_y_mm;
    side_nxt.keep = in_bus.finite && (z_ext > min_ext);
    side_nxt.sx   = in_bus.point_x_mm[COORD_BITS-1];
    side_nxt.sy   = in_bus.point_y_mm[COORD_BITS-1];
    // A kept depth is positive, so its low bits are the whole divisor.
    side_nxt.div  = in_bus.point_z_mm[DB-1:0];
    side_nxt.r    = in_bus.red_in;
    side_nxt.g    = in_bus.green_in;
    side_nxt.b    = in_bus.blue_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
      side_r[0] <= side_nxt;
      for (int k = 1; k < SIDE_N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Stage 1: focal products, loaded as the divider numerators.
  logic [DB-1:0] rem_r [2][PB+1];
  logic [PB-1:0] nq_r  [2][PB+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      nq_r[0][0]  <= PB'(ax_r * fx_r);
      nq_r[1][0]  <= PB'(ay_r * fy_r);
      rem_r[0][0] <= '0;
      rem_r[1][0] <= '0;
    end
  end

  // Divider: one restoring step per stage; quotient bits shift in behind the numerator.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar j = 0; j < PB; j++) begin : g_step
      logic [DB:0]   trial;
      logic          ge;
      logic [DB:0]   diff;
      logic [DB-1:0] rem_nxt;
      logic [PB-1:0] nq_nxt;

      always_comb begin
        trial   = {rem_r[l][j], nq_r[l][j][PB-1]};
        diff    = trial - {1'b0, side_r[j+1].div};
        ge      = trial >= {1'b0, side_r[j+1].div};
        rem_nxt = ge ? diff[DB-1:0] : trial[DB-1:0];
        nq_nxt  = {nq_r[l][j][PB-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[l][j+1] <= rem_nxt;
          nq_r[l][j+1]  <= nq_nxt;
        end
      end
    end
  end

  // Sum stage: restore the quotient sign and add the principal point.
  logic signed [SB-1:0] qx_s, qy_s, sx_nxt, sy_nxt;
  logic signed [SB-1:0] sx_r, sy_r;
  side_t                side_q;

  assign side_q = side_r[PB+1];

  always_comb begin
    qx_s   = side_q.sx ? -$signed({2'b00, nq_r[0][PB]}) : $signed({2'b00, nq_r[0][PB]});
    qy_s   = side_q.sy ? -$signed({2'b00, nq_r[1][PB]}) : $signed({2'b00, nq_r[1][PB]});
    sx_nxt = qx_s + $signed({{(SB-FOCAL_W){1'b0}}, cx_r});
    sy_nxt = qy_s + $signed({{(SB-FOCAL_W){1'b0}}, cy_r});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
  end

  // Output stage: truncate to whole pixels, mirror, clamp.
  // |trunc(s/256)| equals |s| shifted down by the fraction bits.
  localparam logic [LW-1:0] PMAX = LW'((1 << PIXEL_BITS) - 1);

  logic [LW-1:0]         lim_x, lim_y;
  logic [SB-1:0]         absx, absy;
  logic [MB-1:0]         magx, magy;
  logic [PIXEL_BITS-1:0] col_nxt, row_nxt;
  side_t                 side_o;

  assign side_o = side_r[PB+2];

  always_comb begin
    lim_x = (width_r == '0)  ? '0 : LW'(width_r - 1'b1);
    lim_y = (height_r == '0) ? '0 : LW'(height_r - 1'b1);
    if (lim_x > PMAX) lim_x = PMAX;
    if (lim_y > PMAX) lim_y = PMAX;
    absx    = sx_r[SB-1] ? SB'(-sx_r) : SB'(sx_r);
    absy    = sy_r[SB-1] ? SB'(-sy_r) : SB'(sy_r);
    magx    = absx[SB-1:FRAC_BITS];
    magy    = absy[SB-1:FRAC_BITS];
    col_nxt = (magx > MB'(lim_x)) ? lim_x[PIXEL_BITS-1:0] : magx[PIXEL_BITS-1:0];
    row_nxt = (magy > MB'(lim_y)) ? lim_y[PIXEL_BITS-1:0] : magy[PIXEL_BITS-1:0];
  end

  logic                  wp_r;
  logic [PIXEL_BITS-1:0] col_r, row_r;
  logic [COLOR_W-1:0]    red_r, green_r, blue_r;

  // Drop: zero the whole command.
  always_ff @(posedge clk) begin
    if (adv) begin
      wp_r    <= side_o.keep;
      col_r   <= side_o.keep ? col_nxt : '0;
      row_r   <= side_o.keep ? row_nxt : '0;
      red_r   <= side_o.keep ? side_o.r : '0;
      green_r <= side_o.keep ? side_o.g : '0;
      blue_r  <= side_o.keep ? side_o.b : '0;
    end
  end

  assign out_bus.valid       = valid_r[NS-1];
  assign out_bus.write_pixel = wp_r;
  assign out_bus.column      = col_r;
  assign out_bus.row         = row_r;
  assign out_bus.red_out     = red_r;
  assign out_bus.green_out   = green_r;
  assign out_bus.blue_out    = blue_r;

`ifndef SYNTHESIS
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.write_pixel) |->
      (out_bus.column == '0 && out_bus.row == '0 && out_bus.red_out == '0))
    else $error("dropped point carries nonzero payload");

  a_col_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (LW'(out_bus.column) <= lim_x))
    else $error("column beyond clamp limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |=> (out_bus.valid && $stable(out_bus.column)
      && $stable(out_bus.row)))
    else $error("output changed during stall");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import php_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int PB = PIXEL_BITS_DEF;
  localparam int LATENCY = CB + FOCAL_W + 4;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic [COLOR_W-1:0]   r;
    logic [COLOR_W-1:0]   g;
    logic [COLOR_W-1:0]   b;
    logic                 finite;
  } point_t;

  typedef struct packed {
    logic               write_pixel;
    logic [PB-1:0]      column;
    logic [PB-1:0]      row;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } pixel_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  php_in_if  #(.COORD_BITS(CB)) in_bus ();
  php_out_if #(.PIXEL_BITS(PB)) out_bus ();
  php_cfg_if cfg_bus ();

  pinhole_point_projection #(.COORD_BITS(CB), .PIXEL_BITS(PB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_bus(cfg_bus.sink)
  );

  // Shadow copy of the camera registers.
  logic [FOCAL_W-1:0] cam_fx, cam_fy, cam_cx, cam_cy;
  logic [SIZE_W-1:0]  cam_w, cam_h;
  logic [DEPTH_W-1:0] cam_min_z;

  point_t     point_queue[$];
  pixel_cmd_t pixel_queue[$];
  int         mismatch_count = 0;
  bit         no_idle = 1'b0;
  bit         hold_sender = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Project one axis: truncating divide to Q8, add centre, drop the fraction,
  // mirror negatives, clamp to size minus one.
  function automatic logic [PB-1:0] project_axis(longint p, longint z, longint f,
                                                 longint c, longint size);
    longint pix;
    longint limit;
    pix = ((p * f) / z + c) / 256;
    if (pix < 0) pix = -pix;
    limit = (size == 0) ? 0 : size - 1;
    if (limit > (1 << PB) - 1) limit = (1 << PB) - 1;
    if (pix > limit) pix = limit;
    return pix[PB-1:0];
  endfunction

  function automatic pixel_cmd_t project_point(point_t p);
    pixel_cmd_t cmd;
    longint z;
    cmd = '0;
    z = p.z;
    if (!p.finite || z <= longint'(cam_min_z)) return cmd;
    cmd.write_pixel = 1'b1;
    cmd.column = project_axis(p.x, z, cam_fx, cam_cx, cam_w);
    cmd.row    = project_axis(p.y, z, cam_fy, cam_cy, cam_h);
    cmd.r = p.r;
    cmd.g = p.g;
    cmd.b = p.b;
    return cmd;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: advance to the next point after each accepted beat, idle in bursts.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.point_x_mm <= '0;
      in_bus.point_y_mm <= '0;
      in_bus.point_z_mm <= '0;
      in_bus.red_in     <= '0;
      in_bus.green_in   <= '0;
      in_bus.blue_in    <= '0;
      in_bus.finite     <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        pixel_queue.push_back(project_point(point_queue.pop_front()));
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the beat
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (point_queue.size() > 0 && !hold_sender) begin
        if (!no_idle && $urandom_range(0, 19) == 0) begin
          in_gap <= $urandom_range(1, 11);
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.valid      <= 1'b1;
          in_bus.point_x_mm <= point_queue[0].x;
          in_bus.point_y_mm <= point_queue[0].y;
          in_bus.point_z_mm <= point_queue[0].z;
          in_bus.red_in     <= point_queue[0].r;
          in_bus.green_in   <= point_queue[0].g;
          in_bus.blue_in    <= point_queue[0].b;
          in_bus.finite     <= point_queue[0].finite;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted beat, stall the sink in bursts.
  int out_stall = 0;
  always @(posedge clk) begin
    pixel_cmd_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pixel_queue.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = pixel_queue.pop_front();
          if (out_bus.write_pixel !== want.write_pixel)
            report("write_pixel", out_bus.write_pixel, want.write_pixel);
          if (out_bus.column !== want.column) report("column", out_bus.column, want.column);
          if (out_bus.row !== want.row) report("row", out_bus.row, want.row);
          if (out_bus.red_out !== want.r) report("red", out_bus.red_out, want.r);
          if (out_bus.green_out !== want.g) report("green", out_bus.green_out, want.g);
          if (out_bus.blue_out !== want.b) report("blue", out_bus.blue_out, want.b);
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 19) == 0) begin
        out_stall <= $urandom_range(1, 11);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_FOCAL_X:  cam_fx = value[FOCAL_W-1:0];
      REG_FOCAL_Y:  cam_fy = value[FOCAL_W-1:0];
      REG_CENTRE_X: cam_cx = value[FOCAL_W-1:0];
      REG_CENTRE_Y: cam_cy = value[FOCAL_W-1:0];
      REG_WIDTH:    cam_w = value[SIZE_W-1:0];
      REG_HEIGHT:   cam_h = value[SIZE_W-1:0];
      default:      cam_min_z = value[DEPTH_W-1:0];
    endcase
  endtask

  // Wait for the pipeline to drain before touching the registers.
  task automatic drain;
    while (point_queue.size() != 0 || pixel_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic point_t rand_point(bit well_formed);
    point_t p;
    p.x = CB'($urandom);
    p.y = CB'($urandom);
    p.z = CB'($urandom);
    p.r = COLOR_W'($urandom);
    p.g = COLOR_W'($urandom);
    p.b = COLOR_W'($urandom);
    p.finite = well_formed ? ($urandom_range(0, 15) != 0) : 1'($urandom_range(0, 1));
    if (well_formed) begin
      // mostly realistic scenes: depth a bit beyond the threshold
      p.z = CB'(longint'(cam_min_z) + longint'($urandom_range(1, 20000)));
      if ($urandom_range(0, 3) != 0) begin
        p.x = CB'(int'($urandom_range(0, 20000)) - 10000);
        p.y = CB'(int'($urandom_range(0, 20000)) - 10000);
      end
    end
    return p;
  endfunction

  task automatic push_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                            logic signed [CB-1:0] z, logic f);
    point_t p;
    p = '{x: x, y: y, z: z, r: COLOR_W'($urandom), g: COLOR_W'($urandom),
          b: COLOR_W'($urandom), finite: f};
    point_queue.push_back(p);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) point_queue.push_back(rand_point($urandom_range(0, 9) != 0));
    drain();
  endtask

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_FOCAL_X;
    cfg_bus.data = '0;
    cam_fx = FOCAL_X_RST;
    cam_fy = FOCAL_Y_RST;
    cam_cx = CENTRE_X_RST;
    cam_cy = CENTRE_Y_RST;
    cam_w = WIDTH_RST;
    cam_h = HEIGHT_RST;
    cam_min_z = DEPTH_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, field extremes, drop cases.
    push_point(0, 0, 1000, 1'b1);
    push_point(0, 0, 1000, 1'b0);               // non-finite drop
    push_point(0, 0, 460, 1'b1);                // depth at threshold drops
    push_point(0, 0, 461, 1'b1);                // just above threshold
    push_point(0, 0, -5, 1'b1);                 // negative depth drops
    push_point(0, 0, CMIN, 1'b1);
    push_point(CMAX, CMAX, CMAX, 1'b1);
    push_point(CMIN, CMIN, CMAX, 1'b1);
    push_point(CMAX, CMIN, 461, 1'b1);          // clamp high
    push_point(CMIN, CMAX, 461, 1'b1);          // mirror then clamp
    push_point(-1000000, -1000000, 1000, 1'b1); // mirrored coordinate
    push_point(-1, -1, CMAX, 1'b1);
    point_queue.push_back('{x: -1, y: -1, z: CMAX, r: 8'hff, g: 8'hff, b: 8'hff,
                            finite: 1'b1});
    point_queue.push_back('{x: 0, y: 0, z: 5000, r: 8'h00, g: 8'h00, b: 8'h00,
                            finite: 1'b1});

    // Drain the pipeline, then hold the sender with a point queued before continuing.
    drain();
    hold_sender = 1'b1;
    push_point(12345, -6789, 2000, 1'b1);
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;
    random_phase(300);

    // Maximum registers, zero width and unit height, minimum threshold.
    write_reg(REG_FOCAL_X, CFG_DATA_W'((1 << FOCAL_W) - 1));
    write_reg(REG_FOCAL_Y, CFG_DATA_W'((1 << FOCAL_W) - 1));
    write_reg(REG_CENTRE_X, CFG_DATA_W'((1 << FOCAL_W) - 1));
    write_reg(REG_CENTRE_Y, CFG_DATA_W'((1 << FOCAL_W) - 1));
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_MIN_DEPTH, 0);
    push_point(CMAX, CMIN, 1, 1'b1);
    push_point(CMIN, CMAX, 1, 1'b1);
    push_point(0, 0, 0, 1'b1);
    random_phase(250);

    // Oversize images, zero focal and centre, largest threshold.
    write_reg(REG_FOCAL_X, 0);
    write_reg(REG_FOCAL_Y, 0);
    write_reg(REG_CENTRE_X, 0);
    write_reg(REG_CENTRE_Y, 0);
    write_reg(REG_WIDTH, 4096);
    write_reg(REG_HEIGHT, CFG_DATA_W'((1 << SIZE_W) - 1));
    write_reg(REG_MIN_DEPTH, CFG_DATA_W'((1 << DEPTH_W) - 1));
    push_point(5, 5, CMAX, 1'b1);
    push_point(5, 5, CB'((1 << DEPTH_W) - 1), 1'b1);
    random_phase(250);

    // Random settings.
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_FOCAL_X, CFG_DATA_W'($urandom_range(0, (1 << FOCAL_W) - 1)));
      write_reg(REG_FOCAL_Y, CFG_DATA_W'($urandom_range(0, (1 << FOCAL_W) - 1)));
      write_reg(REG_CENTRE_X, CFG_DATA_W'($urandom_range(0, (1 << FOCAL_W) - 1)));
      write_reg(REG_CENTRE_Y, CFG_DATA_W'($urandom_range(0, (1 << FOCAL_W) - 1)));
      write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, 4096)));
      write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, 4096)));
      write_reg(REG_MIN_DEPTH, CFG_DATA_W'($urandom_range(0, 3000)));
      random_phase(250);
    end

    // Last stretch at full rate with no idling.
    write_reg(REG_FOCAL_X, CFG_DATA_W'(FOCAL_X_RST));
    write_reg(REG_FOCAL_Y, CFG_DATA_W'(FOCAL_Y_RST));
    write_reg(REG_CENTRE_X, CFG_DATA_W'(CENTRE_X_RST));
    write_reg(REG_CENTRE_Y, CFG_DATA_W'(CENTRE_Y_RST));
    write_reg(REG_WIDTH, CFG_DATA_W'(WIDTH_RST));
    write_reg(REG_HEIGHT, CFG_DATA_W'(HEIGHT_RST));
    write_reg(REG_MIN_DEPTH, DEPTH_RST);
    no_idle = 1'b1;
    random_phase(200);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
